### rtl/stat_pkg.sv
// ----------------------------------------------------------------------------
// stat_pkg
// Types and constants shared by the segment table address translator files.
// ----------------------------------------------------------------------------
package stat_pkg;

  // opcodes of an input item
  localparam logic [1:0] OP_CLEAR     = 2'd0;
  localparam logic [1:0] OP_ADD       = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;
  localparam logic [1:0] OP_RANGE     = 2'd3;

  // configuration port: registers lie 8 bytes apart
  localparam int unsigned CFG_AW        = 4;
  localparam int unsigned CFG_DW        = 64;
  localparam int unsigned CFG_SEL_BIT   = 3;
  localparam logic        REG_FILE_BASE = 1'b0;
  localparam logic        REG_FILE_SIZE = 1'b1;

  localparam logic [63:0] WINDOW_BYTES  = 64'd8;
  localparam int unsigned PROT_EXEC_BIT = 2;
  localparam logic [47:0] TEXT_PREFIX   = 48'h5F5F54455854;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_WHERE,
    ST_WIN,
    ST_LIMIT,
    ST_SPAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] vm_addr;
    logic [63:0] vm_size;
    logic [63:0] file_offset;
    logic [63:0] file_size;
    logic        exec_text;
  } seg_entry_t;

endpackage

### rtl/stat_ifs.sv
// ----------------------------------------------------------------------------
// stat channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface stat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] seg_vm_addr;
  logic [63:0] seg_vm_size;
  logic [63:0] seg_file_offset;
  logic [63:0] seg_file_size;
  logic [2:0]  seg_max_prot;
  logic [47:0] seg_name_prefix;
  logic [63:0] query_addr;

  modport source (
    output valid, opcode, seg_vm_addr, seg_vm_size, seg_file_offset,
           seg_file_size, seg_max_prot, seg_name_prefix, query_addr,
    input  ready
  );
  modport sink (
    input  valid, opcode, seg_vm_addr, seg_vm_size, seg_file_offset,
           seg_file_size, seg_max_prot, seg_name_prefix, query_addr,
    output ready
  );
endinterface

interface stat_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] file_offset;
  logic [63:0] range_low;
  logic [63:0] range_high;
  logic [63:0] lowest_vm_addr;
  logic [7:0]  segment_count;

  modport source (
    output valid, ok, file_offset, range_low, range_high, lowest_vm_addr,
           segment_count,
    input  ready
  );
  modport sink (
    input  valid, ok, file_offset, range_low, range_high, lowest_vm_addr,
           segment_count,
    output ready
  );
endinterface

### rtl/segment_table_address_translator_top.sv
// Sequence: clear and add answer straight from idle; translate scans up to the first
// covering segment, then SUM, WHERE, WIN, LIMIT, or scans all when none covers; range
// scans all, then SPAN. Table read one entry a cycle, one shared adder.
// Throughput: one item at a time; the next item is taken once the result is out.
// Reset: synchronous, active low; table empty, control state zero, no clearing pass.
// ----------------------------------------------------------------------------
// segment_table_address_translator_top
// Segment table with clear, add, address translation and text range query,
// driven by a small sequencer over one table memory and one shared adder.
// ----------------------------------------------------------------------------
module segment_table_address_translator_top
  import stat_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  stat_in_if.sink           in_ch,
  stat_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  state_t      state_r, state_nxt;

  logic [63:0] file_base_r;
  logic [63:0] file_size_r;
  logic [CW-1:0] total_r;
  logic [63:0] lowest_r;

  seg_entry_t  seg_mem [MAX_SEGMENTS];
  seg_entry_t  mem_q_r;
  seg_entry_t  wr_entry;

  logic [CW-1:0] issue_idx_r;
  logic        pend_r;
  logic        op_range_r;
  logic [63:0] query_r;

  logic [63:0] delta_r;
  logic [63:0] off_r;
  logic [63:0] fsize_r;
  logic [63:0] acc_r;
  logic        win_ok_r;

  logic [63:0] m_lo_r, m_hi_r, a_lo_r, a_hi_r;

  logic        res_ok_r;
  logic [63:0] res_foff_r, res_lo_r, res_hi_r;

  logic        out_valid_r;
  logic        out_ok_r;
  logic [63:0] out_foff_r, out_lo_r, out_hi_r, out_lowest_r;
  logic [7:0]  out_count_r;

  // sequencer outputs
  logic        in_ready;
  logic        rd_en;
  logic        out_free;
  logic [63:0] add_a, add_b, sum;

  logic        in_xfer, cfg_wr, full, covered, scan_done;
  logic [63:0] eff_size;
  logic [CW-1:0] total_inc;
  logic [63:0] lowest_upd;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_xfer   = in_ch.valid && in_ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign full      = (total_r >= CW'(MAX_SEGMENTS));
  assign total_inc = total_r + CW'(1);
  assign scan_done = (issue_idx_r == total_r) && !pend_r;

  assign eff_size  = (mem_q_r.vm_size != 64'd0) ? mem_q_r.vm_size : mem_q_r.file_size;
  // end of segment comes out of the shared adder during the scan
  assign covered   = pend_r && (query_r >= mem_q_r.vm_addr) && (query_r < sum);

  assign lowest_upd = ((lowest_r == 64'd0) || (in_ch.seg_vm_addr < lowest_r)) ?
                      in_ch.seg_vm_addr : lowest_r;

  assign wr_entry.vm_addr     = in_ch.seg_vm_addr;
  assign wr_entry.vm_size     = in_ch.seg_vm_size;
  assign wr_entry.file_offset = in_ch.seg_file_offset;
  assign wr_entry.file_size   = in_ch.seg_file_size;
  assign wr_entry.exec_text   = in_ch.seg_max_prot[PROT_EXEC_BIT] ||
                                (in_ch.seg_name_prefix == TEXT_PREFIX);

  // shared 64-bit adder
  assign sum = add_a + add_b;

  // ---------------- sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_ch.opcode == OP_TRANSLATE || in_ch.opcode == OP_RANGE)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!op_range_r && covered) begin
          state_nxt = ST_SUM;
        end else if (scan_done) begin
          state_nxt = op_range_r ? ST_SPAN : ST_DONE;
        end
      end
      ST_SUM:   state_nxt = ST_WHERE;
      ST_WHERE: state_nxt = ST_WIN;
      ST_WIN:   state_nxt = ST_LIMIT;
      ST_LIMIT: state_nxt = ST_DONE;
      ST_SPAN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    add_a    = 64'd0;
    add_b    = 64'd0;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
      end
      ST_SCAN: begin
        rd_en = (issue_idx_r != total_r);
        add_a = mem_q_r.vm_addr;
        add_b = eff_size;
      end
      ST_SUM: begin
        add_a = file_base_r;
        add_b = off_r;
      end
      ST_WHERE: begin
        add_a = acc_r;
        add_b = delta_r;
      end
      ST_WIN: begin
        add_a = delta_r;
        add_b = WINDOW_BYTES;
      end
      ST_LIMIT: begin
        add_a = acc_r;
        add_b = WINDOW_BYTES;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // ---------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      lowest_r    <= 64'd0;
      file_base_r <= 64'd0;
      file_size_r <= 64'd0;
      issue_idx_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[CFG_SEL_BIT] == REG_FILE_BASE) begin
          file_base_r <= pwdata;
        end else begin
          file_size_r <= pwdata;
        end
      end
      if (in_xfer) begin
        issue_idx_r <= '0;
        pend_r      <= 1'b0;
        if (in_ch.opcode == OP_CLEAR) begin
          total_r  <= '0;
          lowest_r <= 64'd0;
        end else if (in_ch.opcode == OP_ADD && !full) begin
          total_r  <= total_inc;
          lowest_r <= lowest_upd;
        end
      end else if (state_r == ST_SCAN) begin
        pend_r <= rd_en;
        if (rd_en) begin
          issue_idx_r <= issue_idx_r + CW'(1);
        end
      end
      if (in_xfer && (in_ch.opcode == OP_CLEAR || in_ch.opcode == OP_ADD)) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- segment table memory
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.opcode == OP_ADD && !full) begin
      seg_mem[total_r[IW-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      mem_q_r <= seg_mem[issue_idx_r[IW-1:0]];
    end
  end

  // ---------------- datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_range_r <= (in_ch.opcode == OP_RANGE);
      query_r    <= in_ch.query_addr;
      m_lo_r     <= ALL_ONES;
      m_hi_r     <= 64'd0;
      a_lo_r     <= ALL_ONES;
      a_hi_r     <= 64'd0;
      res_ok_r   <= 1'b0;
      res_foff_r <= 64'd0;
      res_lo_r   <= 64'd0;
      res_hi_r   <= 64'd0;
    end
    case (state_r)
      ST_SCAN: begin
        if (covered) begin
          delta_r <= query_r - mem_q_r.vm_addr;
          off_r   <= mem_q_r.file_offset;
          fsize_r <= mem_q_r.file_size;
        end
        if (pend_r) begin
          if (mem_q_r.vm_addr < a_lo_r) a_lo_r <= mem_q_r.vm_addr;
          if (sum > a_hi_r)             a_hi_r <= sum;
          if (mem_q_r.exec_text) begin
            if (mem_q_r.vm_addr < m_lo_r) m_lo_r <= mem_q_r.vm_addr;
            if (sum > m_hi_r)             m_hi_r <= sum;
          end
        end
      end
      ST_SUM:   acc_r    <= sum;
      ST_WHERE: acc_r    <= sum;
      ST_WIN:   win_ok_r <= (sum <= fsize_r);
      ST_LIMIT: begin
        if (win_ok_r && (sum <= file_size_r)) begin
          res_ok_r   <= 1'b1;
          res_foff_r <= acc_r;
        end
      end
      ST_SPAN: begin
        res_ok_r <= 1'b1;
        if (m_lo_r != ALL_ONES && m_hi_r > m_lo_r) begin
          res_lo_r <= m_lo_r;
          res_hi_r <= m_hi_r;
        end else begin
          // no usable text span: fall back to all segments
          res_lo_r <= (a_lo_r == ALL_ONES) ? 64'd0 : a_lo_r;
          res_hi_r <= a_hi_r;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // ---------------- result register
  always_ff @(posedge clk) begin
    if (in_xfer && (in_ch.opcode == OP_CLEAR || in_ch.opcode == OP_ADD)) begin
      out_foff_r <= 64'd0;
      out_lo_r   <= 64'd0;
      out_hi_r   <= 64'd0;
      if (in_ch.opcode == OP_CLEAR) begin
        out_ok_r     <= 1'b1;
        out_lowest_r <= 64'd0;
        out_count_r  <= 8'd0;
      end else if (full) begin
        out_ok_r     <= 1'b0;
        out_lowest_r <= lowest_r;
        out_count_r  <= 8'(total_r);
      end else begin
        out_ok_r     <= 1'b1;
        out_lowest_r <= lowest_upd;
        out_count_r  <= 8'(total_inc);
      end
    end else if (state_r == ST_DONE && out_free) begin
      out_ok_r     <= res_ok_r;
      out_foff_r   <= res_foff_r;
      out_lo_r     <= res_lo_r;
      out_hi_r     <= res_hi_r;
      out_lowest_r <= lowest_r;
      out_count_r  <= 8'(total_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.file_offset    = out_foff_r;
  assign out_ch.range_low      = out_lo_r;
  assign out_ch.range_high     = out_hi_r;
  assign out_ch.lowest_vm_addr = out_lowest_r;
  assign out_ch.segment_count  = out_count_r;

  // ---------------- configuration read
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_SEL_BIT] == REG_FILE_BASE) ? file_base_r : file_size_r;

`ifndef NO_ASSERTIONS
  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> issue_idx_r <= total_r)
    else $error("scan pointer past last segment");

  a_full_add_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.opcode == OP_ADD && full) |=> ($stable(total_r) && !out_ok_r))
    else $error("add into full table changed state");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready)
    else $error("input taken while a lookup is in flight");

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished lookup did not reach the result register");
`endif

endmodule

### tb/sv/tb_segment_table_address_translator_top.sv
// ----------------------------------------------------------------------------
// tb_segment_table_address_translator_top
// Self-checking bench for the segment table: a short table of hand-picked
// transfers, then random segment/lookup traffic under several file settings,
// with random stalls on both channels and one long result-side hold.
// ----------------------------------------------------------------------------
module tb_segment_table_address_translator_top
  import stat_pkg::*;
();

  localparam int unsigned MAX_SEGS    = 128;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam bit          FIXED       = 1'b1;
  localparam bit          CALC        = 1'b0;
  localparam logic [CFG_AW-1:0] ADDR_FILE_BASE =
    {{(CFG_AW-1){1'b0}}, REG_FILE_BASE} << CFG_SEL_BIT;
  localparam logic [CFG_AW-1:0] ADDR_FILE_SIZE =
    {{(CFG_AW-1){1'b0}}, REG_FILE_SIZE} << CFG_SEL_BIT;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] vm_addr;
    logic [63:0] vm_size;
    logic [63:0] file_off;
    logic [63:0] file_sz;
    logic [2:0]  prot;
    logic [47:0] name;
    logic [63:0] query;
  } seg_req_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] foff;
    logic [63:0] rlo;
    logic [63:0] rhi;
    logic [63:0] lowest;
    logic [7:0]  count;
  } seg_rsp_t;

  typedef struct {
    seg_req_t req;
    bit       fixed;
    seg_rsp_t want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  stat_in_if  in_ch ();
  stat_out_if out_ch ();

  segment_table_address_translator_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the segment table and the file registers
  seg_entry_t  seg_rows [MAX_SEGS];
  int unsigned seg_cnt;
  logic [63:0] low_base;
  logic [63:0] cfg_base;
  logic [63:0] cfg_size;

  seg_rsp_t    answers_due [$];
  dir_row_t    dir_rows [$];

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 57;
  bit          hold_req      = 1'b0;
  int unsigned fail_cnt      = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned lookup_hits   = 0;
  int unsigned lookup_misses = 0;
  int unsigned refused_adds  = 0;
  int unsigned cycle_no      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] seg_extent(seg_entry_t e);
    return (e.vm_size != '0) ? e.vm_size : e.file_size;
  endfunction

  function automatic void seg_span(input bit marked_only, output logic [63:0] lo,
                                   output logic [63:0] hi);
    logic [63:0] stop;
    int          i;
    lo = ALL_ONES;
    hi = '0;
    for (i = 0; i < seg_cnt; i++) begin
      if (!marked_only || seg_rows[i].exec_text) begin
        stop = seg_rows[i].vm_addr + seg_extent(seg_rows[i]);
        if (seg_rows[i].vm_addr < lo) lo = seg_rows[i].vm_addr;
        if (stop > hi) hi = stop;
      end
    end
  endfunction

  // applies one accepted transfer to the shadow table and returns its answer
  function automatic seg_rsp_t table_step(seg_req_t r);
    seg_rsp_t    a;
    logic [63:0] lo, hi, base, stop, delta, where, win_end, file_end;
    int          i;
    a    = '0;
    a.ok = 1'b1;
    case (r.opcode)
      OP_CLEAR: begin
        seg_cnt  = 0;
        low_base = '0;
      end
      OP_ADD: begin
        if (seg_cnt >= MAX_SEGS) begin
          a.ok = 1'b0;
          refused_adds++;
        end else begin
          seg_rows[seg_cnt].vm_addr     = r.vm_addr;
          seg_rows[seg_cnt].vm_size     = r.vm_size;
          seg_rows[seg_cnt].file_offset = r.file_off;
          seg_rows[seg_cnt].file_size   = r.file_sz;
          seg_rows[seg_cnt].exec_text   = r.prot[PROT_EXEC_BIT] || (r.name == TEXT_PREFIX);
          seg_cnt++;
          if (low_base == '0 || r.vm_addr < low_base) low_base = r.vm_addr;
        end
      end
      OP_TRANSLATE: begin
        a.ok = 1'b0;
        for (i = 0; i < seg_cnt; i++) begin
          base = seg_rows[i].vm_addr;
          stop = base + seg_extent(seg_rows[i]);
          if (r.query >= base && r.query < stop) begin
            // first covering segment decides, even on a miss
            delta    = r.query - base;
            where    = cfg_base + seg_rows[i].file_offset + delta;
            win_end  = delta + WINDOW_BYTES;
            file_end = where + WINDOW_BYTES;
            if (win_end <= seg_rows[i].file_size && file_end <= cfg_size) begin
              a.ok   = 1'b1;
              a.foff = where;
            end
            break;
          end
        end
        if (a.ok) lookup_hits++;
        else lookup_misses++;
      end
      default: begin
        seg_span(1'b1, lo, hi);
        if (!(lo != ALL_ONES && hi > lo)) begin
          seg_span(1'b0, lo, hi);
          if (lo == ALL_ONES) lo = '0;
        end
        a.rlo = lo;
        a.rhi = hi;
      end
    endcase
    a.lowest = low_base;
    a.count  = 8'(seg_cnt);
    return a;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", what, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_check
    seg_rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $error("result transfer with no answer outstanding");
        fail_cnt++;
      end else begin
        want = answers_due.pop_front();
        check_field("ok", want.ok, out_ch.ok);
        check_field("file_offset", want.foff, out_ch.file_offset);
        check_field("range_low", want.rlo, out_ch.range_low);
        check_field("range_high", want.rhi, out_ch.range_high);
        check_field("lowest_vm_addr", want.lowest, out_ch.lowest_vm_addr);
        check_field("segment_count", want.count, out_ch.segment_count);
      end
    end
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic apb_xfer(input bit wr, input logic [CFG_AW-1:0] addr,
                          input logic [63:0] wdata, output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic apply_setting(input logic [63:0] base, input logic [63:0] size);
    logic [63:0] rd;
    apb_xfer(1'b1, ADDR_FILE_BASE, base, rd);
    apb_xfer(1'b1, ADDR_FILE_SIZE, size, rd);
    cfg_base = base;
    cfg_size = size;
    apb_xfer(1'b0, ADDR_FILE_BASE, '0, rd);
    check_field("file_base readback", base, rd);
    apb_xfer(1'b0, ADDR_FILE_SIZE, '0, rd);
    check_field("file_size readback", size, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_item(input seg_req_t r, input bit fixed, input seg_rsp_t want);
    seg_rsp_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= r.opcode;
    in_ch.seg_vm_addr     <= r.vm_addr;
    in_ch.seg_vm_size     <= r.vm_size;
    in_ch.seg_file_offset <= r.file_off;
    in_ch.seg_file_size   <= r.file_sz;
    in_ch.seg_max_prot    <= r.prot;
    in_ch.seg_name_prefix <= r.name;
    in_ch.query_addr      <= r.query;
    do @(posedge clk); while (!in_ch.ready);
    calc = table_step(r);
    answers_due.push_back(fixed ? want : calc);
    items_sent++;
  endtask

  // block is idle once every answer is back
  task automatic drain();
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic seg_req_t req_add(logic [63:0] vm, logic [63:0] vs, logic [63:0] off,
                                       logic [63:0] fs, logic [2:0] prot, logic [47:0] name);
    seg_req_t r;
    r          = '0;
    r.opcode   = OP_ADD;
    r.vm_addr  = vm;
    r.vm_size  = vs;
    r.file_off = off;
    r.file_sz  = fs;
    r.prot     = prot;
    r.name     = name;
    return r;
  endfunction

  function automatic seg_req_t req_op(logic [1:0] op, logic [63:0] query);
    seg_req_t r;
    r        = '0;
    r.opcode = op;
    r.query  = query;
    return r;
  endfunction

  function automatic seg_rsp_t rsp(logic ok, logic [63:0] foff, logic [63:0] rlo,
                                   logic [63:0] rhi, logic [63:0] lowest, logic [7:0] count);
    seg_rsp_t a;
    a.ok     = ok;
    a.foff   = foff;
    a.rlo    = rlo;
    a.rhi    = rhi;
    a.lowest = lowest;
    a.count  = count;
    return a;
  endfunction

  function automatic logic [63:0] wild64();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return ALL_ONES - 64'($urandom_range(16));
      3:       return 64'($urandom_range(64));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic seg_req_t wild_item();
    seg_req_t r;
    r.opcode   = 2'($urandom_range(3));
    r.vm_addr  = wild64();
    r.vm_size  = wild64();
    r.file_off = wild64();
    r.file_sz  = wild64();
    r.prot     = 3'($urandom_range(7));
    r.name     = 48'({$urandom, $urandom});
    r.query    = wild64();
    return r;
  endfunction

  // plausible segment: modest base, size and offset so that lookups can land
  function automatic seg_req_t make_segment();
    seg_req_t r;
    r          = wild_item();
    r.opcode   = OP_ADD;
    r.vm_addr  = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                          : 64'($urandom_range(32'hFFFF)) << 8;
    r.vm_size  = ($urandom_range(4) == 0) ? '0 : 64'($urandom_range(32'h4000, 1));
    r.file_sz  = ($urandom_range(9) == 0) ? 64'($urandom_range(7))
                                          : 64'($urandom_range(32'h4000, 8));
    r.file_off = 64'($urandom_range(32'hFFFFF));
    r.name     = ($urandom_range(3) == 0) ? TEXT_PREFIX : r.name;
    return r;
  endfunction

  // lookup aimed at the edges of a held segment most of the time
  function automatic seg_req_t make_lookup();
    seg_req_t    r;
    int unsigned k;
    logic [63:0] base, ext;
    r        = wild_item();
    r.opcode = OP_TRANSLATE;
    if (seg_cnt != 0 && $urandom_range(4) != 0) begin
      k    = $urandom_range(seg_cnt - 1);
      base = seg_rows[k].vm_addr;
      ext  = seg_extent(seg_rows[k]);
      case ($urandom_range(4))
        0: r.query = base;
        1: r.query = base + ext - 64'd1;
        2: r.query = base + seg_rows[k].file_size - WINDOW_BYTES + 64'($urandom_range(1));
        3: r.query = base + ext;
        default: r.query = base + 64'($urandom_range(32'h4000));
      endcase
    end
    return r;
  endfunction

  task automatic random_phase(input int unsigned n);
    seg_req_t    r;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        r        = wild_item();
        r.opcode = OP_CLEAR;
      end else if (pick < 31) begin
        r = make_segment();
      end else if (pick < 35) begin
        r        = wild_item();
        r.opcode = OP_ADD;
      end else if (pick < 75) begin
        r = make_lookup();
      end else if (pick < 88) begin
        r        = wild_item();
        r.opcode = OP_RANGE;
      end else begin
        r = wild_item();
      end
      push_item(r, CALC, '0);
    end
    in_ch.valid <= 1'b0;
  endtask

  // fill the table past its limit, then look up through a full table
  task automatic fill_phase();
    seg_req_t r;
    r        = wild_item();
    r.opcode = OP_CLEAR;
    push_item(r, CALC, '0);
    repeat (MAX_SEGS + 3) push_item(make_segment(), CALC, '0);
    repeat (16) push_item(make_lookup(), CALC, '0);
    r        = wild_item();
    r.opcode = OP_RANGE;
    push_item(r, CALC, '0);
    in_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_CLEAR;
    in_ch.seg_vm_addr     <= '0;
    in_ch.seg_vm_size     <= '0;
    in_ch.seg_file_offset <= '0;
    in_ch.seg_file_size   <= '0;
    in_ch.seg_max_prot    <= '0;
    in_ch.seg_name_prefix <= '0;
    in_ch.query_addr      <= '0;
    seg_cnt  = 0;
    low_base = '0;
    cfg_base = '0;
    cfg_size = '0;

    // file base 0x1000, file size 0x10_0000 for the whole table
    dir_rows = '{
      '{req_op(OP_RANGE, 0), FIXED, rsp(1'b1, 0, 0, 0, 0, 0)},
      '{req_op(OP_TRANSLATE, 0), FIXED, rsp(1'b0, 0, 0, 0, 0, 0)},
      // executable only, name is not text
      '{req_add(64'h4000, 64'h1000, 64'h0, 64'h1000, 3'd4, 48'h5F5F_4441_5441),
        FIXED, rsp(1'b1, 0, 0, 0, 64'h4000, 1)},
      // zero vm size, marked by name
      '{req_add(64'h8000, 64'h0, 64'h2000, 64'h800, 3'd3, TEXT_PREFIX),
        FIXED, rsp(1'b1, 0, 0, 0, 64'h4000, 2)},
      '{req_add(64'h2000, 64'h100, 64'h3000, 64'h100, 3'd1, 48'h0),
        FIXED, rsp(1'b1, 0, 0, 0, 64'h2000, 3)},
      // name one letter off the text name, segment data ends at the end of the file
      '{req_add(64'h6000, 64'h1000, 64'hFE000, 64'h2000, 3'd0, 48'h5F5F_5445_5855),
        FIXED, rsp(1'b1, 0, 0, 0, 64'h2000, 4)},
      '{req_op(OP_TRANSLATE, 64'h4010), FIXED, rsp(1'b1, 64'h1010, 0, 0, 64'h2000, 4)},
      '{req_op(OP_TRANSLATE, 64'h4FF8), FIXED, rsp(1'b1, 64'h1FF8, 0, 0, 64'h2000, 4)},
      '{req_op(OP_TRANSLATE, 64'h4FF9), FIXED, rsp(1'b0, 0, 0, 0, 64'h2000, 4)},
      '{req_op(OP_TRANSLATE, 64'h8400), FIXED, rsp(1'b1, 64'h3400, 0, 0, 64'h2000, 4)},
      '{req_op(OP_TRANSLATE, 64'h8800), FIXED, rsp(1'b0, 0, 0, 0, 64'h2000, 4)},
      '{req_op(OP_TRANSLATE, 64'h6FF8), FIXED, rsp(1'b1, 64'hFFFF8, 0, 0, 64'h2000, 4)},
      // window runs past the end of the file
      '{req_op(OP_TRANSLATE, 64'h6FFC), FIXED, rsp(1'b0, 0, 0, 0, 64'h2000, 4)},
      '{req_op(OP_RANGE, 0), FIXED, rsp(1'b1, 0, 64'h4000, 64'h8800, 64'h2000, 4)},
      // segment end wraps past the top of the address space
      '{req_add(ALL_ONES - 64'hF, 64'h20, ALL_ONES, ALL_ONES, 3'd7, 48'hFFFF_FFFF_FFFF),
        FIXED, rsp(1'b1, 0, 0, 0, 64'h2000, 5)},
      '{req_op(OP_TRANSLATE, ALL_ONES - 64'h7), CALC, '0},
      '{req_op(OP_RANGE, 0), CALC, '0},
      '{req_op(OP_CLEAR, ALL_ONES), FIXED, rsp(1'b1, 0, 0, 0, 0, 0)},
      '{req_op(OP_RANGE, 0), FIXED, rsp(1'b1, 0, 0, 0, 0, 0)},
      // base of zero keeps the lowest base at zero, so the next add replaces it
      '{req_add(64'h0, ALL_ONES, 64'h0, 64'h10, 3'd0, 48'h0),
        FIXED, rsp(1'b1, 0, 0, 0, 0, 1)},
      '{req_add(64'h9000, 64'h10, 64'h10, 64'h10, 3'd2, 48'h0),
        FIXED, rsp(1'b1, 0, 0, 0, 64'h9000, 2)},
      // nothing marked: span of all segments
      '{req_op(OP_RANGE, 0), FIXED, rsp(1'b1, 0, 0, ALL_ONES, 64'h9000, 2)},
      '{req_op(OP_TRANSLATE, 64'h8), FIXED, rsp(1'b1, 64'h1008, 0, 0, 64'h9000, 2)},
      // first covering segment misses, later ones are not searched
      '{req_op(OP_TRANSLATE, 64'h9004), FIXED, rsp(1'b0, 0, 0, 0, 64'h9000, 2)},
      '{req_op(OP_TRANSLATE, ALL_ONES), CALC, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 57;
    apply_setting(64'h1000, 64'h10_0000);
    foreach (dir_rows[i]) push_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
    in_ch.valid <= 1'b0;
    drain();

    apply_setting(64'($urandom), ALL_ONES);
    hold_req = 1'b1;
    random_phase(230);
    drain();

    send_idle_pct = 57;
    recv_idle_pct = 15;
    apply_setting(ALL_ONES, ALL_ONES);
    fill_phase();
    drain();

    apply_setting('0, 64'($urandom_range(32'h0100_0000)));
    random_phase(230);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting({$urandom, $urandom}, ALL_ONES - 64'($urandom_range(15)));
    random_phase(210);
    drain();

    apply_setting('0, '0);
    random_phase(20);
    drain();

    // no stray result may follow
    repeat (150) @(posedge clk);
    $display("run covered %0d transfers in, %0d results checked, table filled past its limit",
             items_sent, results_seen);
    $display("lookups: %0d hits, %0d misses; %0d adds refused on a full table",
             lookup_hits, lookup_misses, refused_adds);
    if (fail_cnt == 0 && answers_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
